### hdl/ppd_pkg.sv
// ----------------------------------------------------------------------------
// Polyline point distance package
// Shared command, status and register index types for the controller, the
// datapath and the top level.
// ----------------------------------------------------------------------------
package ppd_pkg;

  localparam int unsigned CFG_INDEX_BITS = 1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CURSOR_X,
    REG_CURSOR_Y
  } cfg_reg_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MAC,
    OP_SQ,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_PICK_CAND,
    OP_PICK_QUOT,
    OP_ROOT_INIT,
    OP_ROOT_STEP,
    OP_CLEAR
  } dp_op_e;

  typedef enum logic [3:0] {
    T_WXVX,
    T_WYVY,
    T_VXVX,
    T_VYVY,
    T_WXWX,
    T_WYWY,
    T_EXEX,
    T_EYEY,
    T_WXVY,
    T_WYVX,
    T_LL,
    T_HL,
    T_HH
  } term_e;

  typedef struct packed {
    dp_op_e op;
    term_e  term;
  } dp_cmd_t;

  typedef struct packed {
    logic c1_le_zero;
    logic c2_le_c1;
  } dp_status_t;

  typedef struct packed {
    logic load;
    logic no_segment;
  } out_ctl_t;

endpackage

### hdl/ppd_datapath.sv
// ----------------------------------------------------------------------------
// Polyline point distance datapath
// Segment vectors, one shared multiply-accumulate unit, cross term squaring,
// serial quotient, running minimum and serial square root.
// ----------------------------------------------------------------------------
module ppd_datapath #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ppd_pkg::dp_cmd_t             cmd_i,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] cursor_x_i,
  input  logic signed [COORD_BITS-1:0] cursor_y_i,
  output ppd_pkg::dp_status_t          status_o,
  output logic [COORD_BITS:0]          distance_o
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned DW = C + 1;
  localparam int unsigned MW = C + 2;
  localparam int unsigned PW = 2 * C + 3;
  localparam int unsigned BW = 2 * C + 2;
  localparam int unsigned CW = 2 * C + 1;
  localparam int unsigned SW = 4 * C + 2;
  localparam int unsigned RW = C + 2;
  localparam int unsigned TW = C + 4;

  logic signed [C-1:0]    prev_x_q, prev_y_q;
  logic signed [DW-1:0]   vx_q, vy_q, wx_q, wy_q, ex_q, ey_q;
  logic signed [DW-1:0]   vx_d, vy_d, wx_d, wy_d, ex_d, ey_d;
  logic signed [DW-1:0]   px_e, py_e, ax_e, ay_e, cx_e, cy_e;
  logic signed [PW-1:0]   acc_q, c1_q;
  logic [BW-1:0]          c2_q, cand_q, best_q;
  logic [CW-1:0]          cr_q, cr_mag;
  logic [SW-1:0]          sq_q;
  logic [BW-1:0]          rem_q, dvd_q;
  logic [BW:0]            div_t;
  logic                   div_ge;
  logic [BW-1:0]          rad_q;
  logic [RW-1:0]          sqrem_q;
  logic [C:0]             root_q;
  logic [TW-1:0]          root_t, root_trial;
  logic                   root_ge;
  logic signed [MW-1:0]   ma, mb;
  logic signed [2*MW-1:0] prod_full;
  logic signed [PW-1:0]   prod, sum, diff, diff_neg;
  logic [BW-1:0]          prod_u;

  always_comb begin
    px_e = {point_x_i[C-1], point_x_i};
    py_e = {point_y_i[C-1], point_y_i};
    ax_e = {prev_x_q[C-1], prev_x_q};
    ay_e = {prev_y_q[C-1], prev_y_q};
    cx_e = {cursor_x_i[C-1], cursor_x_i};
    cy_e = {cursor_y_i[C-1], cursor_y_i};
    vx_d = px_e - ax_e;
    vy_d = py_e - ay_e;
    wx_d = cx_e - ax_e;
    wy_d = cy_e - ay_e;
    ex_d = cx_e - px_e;
    ey_d = cy_e - py_e;
  end

  always_comb begin
    unique case (cmd_i.term)
      ppd_pkg::T_WXVX: begin ma = {wx_q[DW-1], wx_q}; mb = {vx_q[DW-1], vx_q}; end
      ppd_pkg::T_WYVY: begin ma = {wy_q[DW-1], wy_q}; mb = {vy_q[DW-1], vy_q}; end
      ppd_pkg::T_VXVX: begin ma = {vx_q[DW-1], vx_q}; mb = {vx_q[DW-1], vx_q}; end
      ppd_pkg::T_VYVY: begin ma = {vy_q[DW-1], vy_q}; mb = {vy_q[DW-1], vy_q}; end
      ppd_pkg::T_WXWX: begin ma = {wx_q[DW-1], wx_q}; mb = {wx_q[DW-1], wx_q}; end
      ppd_pkg::T_WYWY: begin ma = {wy_q[DW-1], wy_q}; mb = {wy_q[DW-1], wy_q}; end
      ppd_pkg::T_EXEX: begin ma = {ex_q[DW-1], ex_q}; mb = {ex_q[DW-1], ex_q}; end
      ppd_pkg::T_EYEY: begin ma = {ey_q[DW-1], ey_q}; mb = {ey_q[DW-1], ey_q}; end
      ppd_pkg::T_WXVY: begin ma = {wx_q[DW-1], wx_q}; mb = {vy_q[DW-1], vy_q}; end
      ppd_pkg::T_WYVX: begin ma = {wy_q[DW-1], wy_q}; mb = {vx_q[DW-1], vx_q}; end
      ppd_pkg::T_LL: begin
        ma = {1'b0, cr_q[C:0]};
        mb = {1'b0, cr_q[C:0]};
      end
      ppd_pkg::T_HL: begin
        ma = {2'b00, cr_q[CW-1:C+1]};
        mb = {1'b0, cr_q[C:0]};
      end
      ppd_pkg::T_HH: begin
        ma = {2'b00, cr_q[CW-1:C+1]};
        mb = {2'b00, cr_q[CW-1:C+1]};
      end
      default: begin ma = '0; mb = '0; end
    endcase
    prod_full = ma * mb;
    prod      = prod_full[PW-1:0];
    prod_u    = prod[BW-1:0];
    sum       = acc_q + prod;
    diff      = acc_q - prod;
    diff_neg  = -diff;
    cr_mag    = diff[PW-1] ? diff_neg[CW-1:0] : diff[CW-1:0];
  end

  always_comb begin
    div_t  = {rem_q, dvd_q[BW-1]};
    div_ge = div_t >= {1'b0, c2_q};
  end

  always_comb begin
    root_t     = {sqrem_q, rad_q[BW-1:BW-2]};
    root_trial = {1'b0, root_q, 2'b01};
    root_ge    = root_t >= root_trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
      best_q   <= '1;
    end else begin
      unique case (cmd_i.op)
        ppd_pkg::OP_LOAD: begin
          prev_x_q <= point_x_i;
          prev_y_q <= point_y_i;
        end
        ppd_pkg::OP_PICK_CAND: begin
          if (cand_q < best_q) begin
            best_q <= cand_q;
          end
        end
        ppd_pkg::OP_PICK_QUOT: begin
          if (dvd_q < best_q) begin
            best_q <= dvd_q;
          end
        end
        ppd_pkg::OP_CLEAR: begin
          prev_x_q <= '0;
          prev_y_q <= '0;
          best_q   <= '1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      ppd_pkg::OP_LOAD: begin
        vx_q <= vx_d;
        vy_q <= vy_d;
        wx_q <= wx_d;
        wy_q <= wy_d;
        ex_q <= ex_d;
        ey_q <= ey_d;
      end
      ppd_pkg::OP_MAC: begin
        unique case (cmd_i.term)
          ppd_pkg::T_WXVX, ppd_pkg::T_VXVX, ppd_pkg::T_WXWX,
          ppd_pkg::T_EXEX, ppd_pkg::T_WXVY: acc_q <= prod;
          ppd_pkg::T_WYVY:                  c1_q <= sum;
          ppd_pkg::T_VYVY:                  c2_q <= sum[BW-1:0];
          ppd_pkg::T_WYWY, ppd_pkg::T_EYEY: cand_q <= sum[BW-1:0];
          ppd_pkg::T_WYVX:                  cr_q <= cr_mag;
          default: ;
        endcase
      end
      ppd_pkg::OP_SQ: begin
        unique case (cmd_i.term)
          ppd_pkg::T_LL: sq_q <= SW'(prod_u);
          ppd_pkg::T_HL: sq_q <= sq_q + (SW'(prod_u) << (C + 2));
          ppd_pkg::T_HH: sq_q <= sq_q + (SW'(prod_u) << BW);
          default: ;
        endcase
      end
      ppd_pkg::OP_DIV_INIT: begin
        rem_q <= BW'(sq_q[SW-1:BW]);
        dvd_q <= sq_q[BW-1:0];
      end
      ppd_pkg::OP_DIV_STEP: begin
        rem_q <= div_ge ? BW'(div_t - {1'b0, c2_q}) : div_t[BW-1:0];
        dvd_q <= {dvd_q[BW-2:0], div_ge};
      end
      ppd_pkg::OP_ROOT_INIT: begin
        rad_q   <= best_q;
        sqrem_q <= '0;
        root_q  <= '0;
      end
      ppd_pkg::OP_ROOT_STEP: begin
        sqrem_q <= root_ge ? RW'(root_t - root_trial) : root_t[RW-1:0];
        root_q  <= {root_q[C-1:0], root_ge};
        rad_q   <= rad_q << 2;
      end
      default: ;
    endcase
  end

  assign status_o.c1_le_zero = c1_q[PW-1] || (c1_q == '0);
  assign status_o.c2_le_c1   = $signed({1'b0, c2_q}) <= c1_q;
  assign distance_o          = root_q;

endmodule

### hdl/ppd_ctrl.sv
// ----------------------------------------------------------------------------
// Polyline point distance controller
// Sequences the datapath per point, tracks the path and owns the result
// handshake.
// ----------------------------------------------------------------------------
module ppd_ctrl #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output ppd_pkg::out_ctl_t   out_ctl_o,
  output ppd_pkg::dp_cmd_t    cmd_o,
  input  ppd_pkg::dp_status_t status_i
);

  localparam int unsigned DIV_STEPS  = 2 * COORD_BITS + 2;
  localparam int unsigned ROOT_STEPS = COORD_BITS + 1;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAC,
    S_DECIDE,
    S_SQ,
    S_DIV_INIT,
    S_DIV,
    S_PICK_C,
    S_PICK_Q,
    S_FINISH,
    S_ROOT_INIT,
    S_ROOT,
    S_EMIT
  } state_e;

  state_e                 state_q;
  ppd_pkg::term_e         term_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   last_q;
  logic                   had_q;
  logic                   have_prev_q;
  logic                   out_valid_q;
  logic                   out_free;
  logic                   emit;

  assign out_free    = !out_valid_q || out_ready_i;
  assign emit        = (state_q == S_EMIT) && out_free;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  assign out_ctl_o.load       = emit;
  assign out_ctl_o.no_segment = !had_q;

  always_comb begin
    cmd_o.term = term_q;
    unique case (state_q)
      S_IDLE:      cmd_o.op = in_valid_i ? ppd_pkg::OP_LOAD : ppd_pkg::OP_NONE;
      S_MAC:       cmd_o.op = ppd_pkg::OP_MAC;
      S_SQ:        cmd_o.op = ppd_pkg::OP_SQ;
      S_DIV_INIT:  cmd_o.op = ppd_pkg::OP_DIV_INIT;
      S_DIV:       cmd_o.op = ppd_pkg::OP_DIV_STEP;
      S_PICK_C:    cmd_o.op = ppd_pkg::OP_PICK_CAND;
      S_PICK_Q:    cmd_o.op = ppd_pkg::OP_PICK_QUOT;
      S_ROOT_INIT: cmd_o.op = ppd_pkg::OP_ROOT_INIT;
      S_ROOT:      cmd_o.op = ppd_pkg::OP_ROOT_STEP;
      S_EMIT:      cmd_o.op = out_free ? ppd_pkg::OP_CLEAR : ppd_pkg::OP_NONE;
      default:     cmd_o.op = ppd_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      term_q      <= ppd_pkg::T_WXVX;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      had_q       <= 1'b0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      priority if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            last_q      <= in_last_i;
            had_q       <= have_prev_q;
            have_prev_q <= 1'b1;
            if (have_prev_q) begin
              state_q <= S_MAC;
              term_q  <= ppd_pkg::T_WXVX;
            end else if (in_last_i) begin
              state_q <= S_EMIT;
            end
          end
        end
        S_MAC: begin
          unique case (term_q)
            ppd_pkg::T_WXVX: term_q <= ppd_pkg::T_WYVY;
            ppd_pkg::T_WYVY: term_q <= ppd_pkg::T_VXVX;
            ppd_pkg::T_VXVX: term_q <= ppd_pkg::T_VYVY;
            ppd_pkg::T_VYVY: state_q <= S_DECIDE;
            ppd_pkg::T_WXWX: term_q <= ppd_pkg::T_WYWY;
            ppd_pkg::T_EXEX: term_q <= ppd_pkg::T_EYEY;
            ppd_pkg::T_WYWY, ppd_pkg::T_EYEY: state_q <= S_PICK_C;
            ppd_pkg::T_WXVY: term_q <= ppd_pkg::T_WYVX;
            ppd_pkg::T_WYVX: begin
              state_q <= S_SQ;
              term_q  <= ppd_pkg::T_LL;
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_DECIDE: begin
          state_q <= S_MAC;
          priority if (status_i.c1_le_zero) begin
            term_q <= ppd_pkg::T_WXWX;
          end else if (status_i.c2_le_c1) begin
            term_q <= ppd_pkg::T_EXEX;
          end else begin
            term_q <= ppd_pkg::T_WXVY;
          end
        end
        S_SQ: begin
          unique case (term_q)
            ppd_pkg::T_LL: term_q <= ppd_pkg::T_HL;
            ppd_pkg::T_HL: term_q <= ppd_pkg::T_HH;
            default:       state_q <= S_DIV_INIT;
          endcase
        end
        S_DIV_INIT: begin
          cnt_q   <= CNT_W'(DIV_STEPS - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (cnt_q == '0) begin
            state_q <= S_PICK_Q;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_PICK_C, S_PICK_Q: begin
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          state_q <= last_q ? S_ROOT_INIT : S_IDLE;
        end
        S_ROOT_INIT: begin
          cnt_q   <= CNT_W'(ROOT_STEPS - 1);
          state_q <= S_ROOT;
        end
        S_ROOT: begin
          if (cnt_q == '0) begin
            state_q <= S_EMIT;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            have_prev_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/polyline_point_distance_core.sv
// ----------------------------------------------------------------------------
// Polyline point distance core
// Least distance from a cursor point to a streamed 2D polyline.
// A point with no previous point is only stored; a segment whose nearest point
// is an end point needs the projection terms and one squared distance; a segment
// needing the projection quotient adds the cross term squaring and the
// bit-serial divider. The last point adds the serial square root, and the
// result register accepts new points while a result waits. Reset clears the
// cursor, the path state and the result valid flag.
// ----------------------------------------------------------------------------
module polyline_point_distance_core #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // point_x, point_y
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
  // last_point
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // distance
  output logic [((COORD_BITS+8)/8)*8-1:0]      m_axis_tdata,
  // no_segment
  output logic                                 m_axis_tuser,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ppd_pkg::CFG_INDEX_BITS-1:0]   cfg_index_i,
  input  logic [COORD_BITS-1:0]                cfg_data_i
);

  localparam int unsigned OUT_DATA_W = ((COORD_BITS + 8) / 8) * 8;

  logic signed [COORD_BITS-1:0] cursor_x_q, cursor_y_q;
  logic signed [COORD_BITS-1:0] point_x, point_y;
  logic [COORD_BITS:0]          distance;
  logic [COORD_BITS:0]          dist_q;
  logic                         noseg_q;
  ppd_pkg::dp_cmd_t             cmd;
  ppd_pkg::dp_status_t          status;
  ppd_pkg::out_ctl_t            out_ctl;

  assign point_x     = s_axis_tdata[COORD_BITS-1:0];
  assign point_y     = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (ppd_pkg::cfg_reg_e'(cfg_index_i))
        ppd_pkg::REG_CURSOR_X: cursor_x_q <= cfg_data_i;
        ppd_pkg::REG_CURSOR_Y: cursor_y_q <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ctl.load) begin
      dist_q  <= out_ctl.no_segment ? '0 : distance;
      noseg_q <= out_ctl.no_segment;
    end
  end

  assign m_axis_tdata = OUT_DATA_W'(dist_q);
  assign m_axis_tuser = noseg_q;

  ppd_ctrl #(
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ctl_o   (out_ctl),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  ppd_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .point_x_i  (point_x),
    .point_y_i  (point_y),
    .cursor_x_i (cursor_x_q),
    .cursor_y_i (cursor_y_q),
    .status_o   (status),
    .distance_o (distance)
  );

endmodule

### sim/tb_polyline_point_distance_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polyline point distance core testbench
// Streams 2D paths into the core and checks each path-end result against a
// behavioral predictor of the least cursor-to-segment distance. Covers the
// single-point path, the three segment regions, coordinate extremes, random
// paths under source and sink idling, and a long sink stall.
// ----------------------------------------------------------------------------
module tb_polyline_point_distance_core;

  localparam int unsigned COORD_BITS  = 16;
  localparam int unsigned DRAIN_PAD   = 100;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [16:0] distance;
    logic        no_segment;
  } dist_result_t;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [31:0]                        s_axis_tdata = '0;
  logic                               s_axis_tlast = 1'b0;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [23:0]                        m_axis_tdata;
  logic                               m_axis_tuser;
  logic                               cfg_valid_i = 1'b0;
  logic                               cfg_ready_o;
  logic [ppd_pkg::CFG_INDEX_BITS-1:0] cfg_index_i = '0;
  logic [COORD_BITS-1:0]              cfg_data_i = '0;

  dist_result_t       expected_q[$];
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  int                 src_idle_pct = 20;
  int                 sink_idle_pct = 20;
  int                 hold_reqs = 0;
  int                 hold_seen = 0;
  int                 hold_left = 0;

  logic signed [15:0] cursor_x_q = '0;
  logic signed [15:0] cursor_y_q = '0;
  logic signed [15:0] path_x = '0;
  logic signed [15:0] path_y = '0;
  logic               path_open = 1'b0;
  logic [33:0]        path_best = '1;

  polyline_point_distance_core #(
    .COORD_BITS(COORD_BITS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_polyline_point_distance_core: FAIL");
      $finish;
    end
  end

  // sink ready: random idling, or a counted hold-off on request
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen     <= hold_reqs;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // track cursor writes and point transfers, predict the path-end distance
  always @(posedge clk_i) begin
    longint       ax, ay, bx, by, cx, cy, vx, vy, wx, wy, c1, c2, cr, cand;
    logic [71:0]  cr_w;
    logic [33:0]  seg_sq;
    logic [16:0]  root;
    dist_result_t res;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == ppd_pkg::REG_CURSOR_X) cursor_x_q = cfg_data_i;
        else if (cfg_index_i == ppd_pkg::REG_CURSOR_Y) cursor_y_q = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        bx = $signed(s_axis_tdata[15:0]);
        by = $signed(s_axis_tdata[31:16]);
        if (path_open) begin
          ax = path_x;
          ay = path_y;
          cx = cursor_x_q;
          cy = cursor_y_q;
          vx = bx - ax;
          vy = by - ay;
          wx = cx - ax;
          wy = cy - ay;
          c1 = wx * vx + wy * vy;
          c2 = vx * vx + vy * vy;
          if (c1 <= 0) begin
            seg_sq = 34'(wx * wx + wy * wy);
          end else if (c2 <= c1) begin
            seg_sq = 34'((cx - bx) * (cx - bx) + (cy - by) * (cy - by));
          end else begin
            cr = wx * vy - wy * vx;
            if (cr < 0) cr = -cr;
            cr_w   = 72'(cr);
            seg_sq = 34'((cr_w * cr_w) / 72'(c2));
          end
          if (seg_sq < path_best) path_best = seg_sq;
        end
        if (s_axis_tlast) begin
          root = '0;
          if (path_open) begin
            for (int b = 16; b >= 0; b--) begin
              cand = root | (longint'(1) << b);
              if (cand * cand <= path_best) root = 17'(cand);
            end
          end
          res.distance   = root;
          res.no_segment = !path_open;
          expected_q.insert(expected_q.size(), res);
          path_open = 1'b0;
          path_best = '1;
          path_x    = '0;
          path_y    = '0;
        end else begin
          path_x    = bx;
          path_y    = by;
          path_open = 1'b1;
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    dist_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 0);
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata[16:0] !== want.distance)
          report_mismatch("distance", m_axis_tdata[16:0], want.distance);
        if (m_axis_tdata[23:17] !== '0)
          report_mismatch("tdata padding", m_axis_tdata[23:17], 0);
        if (m_axis_tuser !== want.no_segment)
          report_mismatch("no_segment", m_axis_tuser, want.no_segment);
      end
    end
  end

  // call at a rising edge; tvalid stays high after the transfer
  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  task automatic set_cursor(input logic signed [15:0] x, input logic signed [15:0] y);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= ppd_pkg::REG_CURSOR_X;
    cfg_data_i  <= x;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= ppd_pkg::REG_CURSOR_Y;
    cfg_data_i  <= y;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_coord(input logic signed [15:0] centre);
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0:       return 16'sh7fff;
          1:       return 16'sh8000;
          2:       return 16'sh0000;
          default: return -16'sd1;
        endcase
      end
      1:       return 16'(int'(centre) + int'($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_single_point();
    send_point(16'sh7fff, 16'sh8000, 1'b1);
    send_point(-16'sd1, 16'sd0, 1'b1);
  endtask

  // cursor still at its reset value here
  task automatic test_segment_regions();
    send_point(16'sd5, 16'sd7, 1'b0);
    send_point(16'sd5, 16'sd7, 1'b1);
    send_point(16'sd10, 16'sd0, 1'b0);
    send_point(16'sd20, 16'sd0, 1'b1);
    send_point(-16'sd20, 16'sd0, 1'b0);
    send_point(-16'sd10, 16'sd0, 1'b1);
    send_point(-16'sd10, 16'sd5, 1'b0);
    send_point(16'sd10, 16'sd5, 1'b1);
  endtask

  task automatic test_extremes();
    wait_drain();
    set_cursor(16'sh8000, 16'sh8000);
    send_point(16'sh7fff, 16'sh7fff, 1'b0);
    send_point(16'sh7fff, 16'sh8000, 1'b0);
    send_point(16'sh8000, 16'sh7fff, 1'b1);
    wait_drain();
    set_cursor(16'sh7fff, 16'sh8000);
    send_point(16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sh7fff, 16'sh7fff, 1'b1);
    wait_drain();
    set_cursor(16'sh7fff, 16'sh7fff);
    send_point(16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sh8000, 16'sh8000, 1'b1);
  endtask

  task automatic test_random_paths(input int n_items, input int src_pct, input int sink_pct);
    int                 sent;
    int                 len;
    int                 r;
    logic signed [15:0] x, y;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (int round = 0; round < 5; round++) begin
      wait_drain();
      set_cursor(pick_coord(cursor_x_q), pick_coord(cursor_y_q));
      sent = 0;
      while (sent < n_items / 5) begin
        r   = $urandom_range(99);
        len = (r < 12) ? 1 : (r < 90) ? $urandom_range(2, 6) : $urandom_range(7, 24);
        x   = pick_coord(cursor_x_q);
        y   = pick_coord(cursor_y_q);
        for (int i = 0; i < len; i++) begin
          if (i != 0 && $urandom_range(9) != 0) begin
            x = pick_coord(cursor_x_q);
            y = pick_coord(cursor_y_q);
          end
          send_point(x, y, i == len - 1);
          sent++;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    wait_drain();
    set_cursor(pick_coord(16'sd0), pick_coord(16'sd0));
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_reqs    <= hold_reqs + 1;
    for (int p = 0; p < 10; p++) begin
      send_point(pick_coord(cursor_x_q), pick_coord(cursor_y_q), 1'b0);
      send_point(pick_coord(cursor_x_q), pick_coord(cursor_y_q), 1'b0);
      send_point(pick_coord(cursor_x_q), pick_coord(cursor_y_q), 1'b1);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_point();
    test_segment_regions();
    test_extremes();
    test_random_paths(490, 37, 68);
    test_random_paths(490, 68, 37);
    test_random_paths(490, 0, 0);
    test_backpressure();
    wait_drain();
    if (expected_q.size() != 0) report_mismatch("results missing", 0, expected_q.size());
    if (mismatch_count == 0) begin
      $display("tb_polyline_point_distance_core: PASS");
    end else begin
      $display("tb_polyline_point_distance_core: FAIL");
    end
    $finish;
  end

endmodule
